// ===== sv/kabf_pkg.sv =====
// ----------------------------------------------------------------------------
// kabf_pkg: shared types and constants for the angle/bias Kalman filter
// Widths, register indexes, controller states, datapath commands and a saturation function.
// ----------------------------------------------------------------------------
package kabf_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned RegW         = 31;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned AngleFracDef = 16;
  localparam int unsigned CovFracDef   = 28;

  // Register reset values (unsigned Q3.28)
  localparam logic [RegW-1:0] QAngleRst   = 31'd2684355;
  localparam logic [RegW-1:0] QGyroRst    = 31'd80531;
  localparam logic [RegW-1:0] RAngleRst   = 31'd2684355;
  localparam logic [RegW-1:0] TimeStepRst = 31'd2684355;

  typedef enum logic [CfgIdxW-1:0] {
    REG_Q_ANGLE   = 2'd0,
    REG_Q_GYRO    = 2'd1,
    REG_R_ANGLE   = 2'd2,
    REG_TIME_STEP = 2'd3
  } reg_idx_e;

  // Datapath micro-operations, one per controller step
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_M_PRED,
    OP_M_T10,
    OP_M_T01,
    OP_M_QA,
    OP_M_T11,
    OP_M_QG,
    OP_FORM_P,
    OP_FORM_S,
    OP_DIV0_START,
    OP_DIV1_START,
    OP_M_K0Y,
    OP_M_K1Y,
    OP_M_K0P00,
    OP_M_K0P01,
    OP_M_K1P00,
    OP_M_K1P01,
    OP_COMMIT
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_M_PRED,
    ST_M_T10,
    ST_M_T01,
    ST_M_QA,
    ST_M_T11,
    ST_M_QG,
    ST_FORM_P,
    ST_FORM_S,
    ST_DIV0,
    ST_DIV0_WAIT,
    ST_DIV1,
    ST_DIV1_WAIT,
    ST_M_K0Y,
    ST_M_K1Y,
    ST_M_K0P00,
    ST_M_K0P01,
    ST_M_K1P00,
    ST_M_K1P01,
    ST_COMMIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[DataW-1:0];
  endfunction

endpackage

// ===== sv/kabf_if.sv =====
// ----------------------------------------------------------------------------
// kabf_if: valid/ready channel interfaces for the filter
// Sample, result and register write channels.
// ----------------------------------------------------------------------------
interface kabf_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        acc_angle;
  logic signed [31:0]        gyro_rate;
  modport source (output valid, acc_angle, gyro_rate, input ready);
  modport sink   (input valid, acc_angle, gyro_rate, output ready);
endinterface

interface kabf_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        angle_estimate;
  modport source (output valid, angle_estimate, input ready);
  modport sink   (input valid, angle_estimate, output ready);
endinterface

interface kabf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/kalman_angle_bias_filter.sv =====
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter: two-state angle/gyro-bias Kalman filter
// Fuses an accelerometer angle with a gyro rate, one angle per sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   sample channel (acc_angle, gyro_rate), one beat per sample.
//   out_if  result channel (angle_estimate), one beat per sample.
//   cfg_if  register writes (q_angle, q_gyro, r_angle, time_step), always
//           ready; write only while no sample is in flight.
// Divider: the two gain divisions run on the bit-serial divider, whose run
//   grows with COV_FRAC_BITS, and take most of the time from accepted
//   sample to result.
// Throughput: one sample at a time; the next sample is taken the cycle
//   after the result beat.
// Reset: state and covariance clear to zero, registers take their defaults.
// Stall: the result holds on out_if until taken; input stays not ready.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter #(
  parameter int unsigned COV_FRAC_BITS = kabf_pkg::CovFracDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kabf_in_if.sink    in_if,
  kabf_out_if.source out_if,
  kabf_cfg_if.sink   cfg_if
);
  logic [30:0] q_angle_q, q_gyro_q, r_angle_q, time_step_q;
  kabf_pkg::dp_cmd_t cmd;
  kabf_pkg::dp_sts_t sts;

  // configuration registers
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_angle_q   <= kabf_pkg::QAngleRst;
      q_gyro_q    <= kabf_pkg::QGyroRst;
      r_angle_q   <= kabf_pkg::RAngleRst;
      time_step_q <= kabf_pkg::TimeStepRst;
    end else if (cfg_if.valid) begin
      unique case (kabf_pkg::reg_idx_e'(cfg_if.index))
        kabf_pkg::REG_Q_ANGLE:   q_angle_q   <= cfg_if.data[30:0];
        kabf_pkg::REG_Q_GYRO:    q_gyro_q    <= cfg_if.data[30:0];
        kabf_pkg::REG_R_ANGLE:   r_angle_q   <= cfg_if.data[30:0];
        kabf_pkg::REG_TIME_STEP: time_step_q <= cfg_if.data[30:0];
        default: ;
      endcase
    end
  end

  kabf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  kabf_datapath #(.CovFrac(COV_FRAC_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .acc_angle_i (in_if.acc_angle),
    .gyro_rate_i (in_if.gyro_rate),
    .q_angle_i   (q_angle_q),
    .q_gyro_i    (q_gyro_q),
    .r_angle_i   (r_angle_q),
    .time_step_i (time_step_q),
    .angle_o     (out_if.angle_estimate)
  );

  // input and output never handshake in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid))
    else $error("input ready while result pending");

  // accepting a sample starts processing: no result valid and input not ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !out_if.valid && !in_if.ready)
    else $error("sample accept did not start processing");

  // the estimate does not move while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> $stable(out_if.angle_estimate))
    else $error("result changed while stalled");
endmodule

// ===== sv/kabf_div.sv =====
// ----------------------------------------------------------------------------
// kabf_div: iterative signed divider for the Kalman gains
// Computes sat32((p << FRAC) / s), s > 0, truncating toward zero; one bit
// per cycle over the widened dividend.
// ----------------------------------------------------------------------------
module kabf_div #(
  parameter int unsigned CovFrac = kabf_pkg::CovFracDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [31:0]       p_i,
  input  logic [32:0]              s_i,
  output logic                     busy_o,
  output logic signed [31:0]       q_o
);
  localparam int unsigned NumW = 32 + CovFrac;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [33:0]     rem_q, rem_d;
  logic [32:0]     den_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [33:0]     trial;
  logic [31:0]     pmag;
  logic signed [65:0] sq;

  assign pmag  = p_i[31] ? 32'(-p_i) : 32'(p_i);
  assign trial = {rem_q[32:0], num_q[NumW-1]};

  // restoring shift/subtract step
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = trial - {1'b0, den_q};
        num_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NumW);
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {pmag, {CovFrac{1'b0}}};
      rem_q <= '0;
      den_q <= s_i;
      neg_q <= p_i[31];
    end else begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign sq     = neg_q ? -$signed({2'b00, 64'(num_q)}) : $signed({2'b00, 64'(num_q)});
  assign q_o    = kabf_pkg::sat32(sq);
  assign busy_o = busy_q;
endmodule

// ===== sv/kabf_datapath.sv =====
// ----------------------------------------------------------------------------
// kabf_datapath: registers, shared multiplier and divider of the filter
// Executes one micro-operation per cycle as commanded by the controller, which holds while the divider is busy.
// ----------------------------------------------------------------------------
module kabf_datapath #(
  parameter int unsigned CovFrac = kabf_pkg::CovFracDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kabf_pkg::dp_cmd_t         cmd_i,
  output kabf_pkg::dp_sts_t         sts_o,
  input  logic signed [31:0]        acc_angle_i,
  input  logic signed [31:0]        gyro_rate_i,
  input  logic [30:0]               q_angle_i,
  input  logic [30:0]               q_gyro_i,
  input  logic [30:0]               r_angle_i,
  input  logic [30:0]               time_step_i,
  output logic signed [31:0]        angle_o
);
  // state
  logic signed [31:0] angle_q, bias_q, c00_q, c01_q, c10_q, c11_q;
  // sample and temporaries
  logic signed [31:0] acc_q, rate_q;
  logic signed [31:0] pred_q, p00_q, p01_q, p10_q, p11_q, y_q, k0_q, k1_q;
  // scaled products keep their full range until the saturating sums
  logic signed [63:0] mt10_q, mt01_q, mqa_q, mt11_q, mqg_q;
  logic signed [63:0] mk0y_q, mk1y_q, mk0p00_q, mk0p01_q, mk1p00_q, mk1p01_q;
  logic signed [33:0] s_q;
  logic signed [63:0] mpred_q;

  // shared multiplier operand select
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod;
  logic signed [65:0] rnd;
  logic signed [65:0] mres;
  logic signed [33:0] ts;

  assign ts = {3'b000, time_step_i};

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.op)
      kabf_pkg::OP_M_PRED:  begin ma = 33'(ts); mb = 33'(rate_q) - 33'(bias_q); end
      kabf_pkg::OP_M_T10:   begin ma = 33'(ts); mb = 33'(c10_q); end
      kabf_pkg::OP_M_T01:   begin ma = 33'(ts); mb = 33'(c01_q); end
      kabf_pkg::OP_M_QA:    begin ma = {2'b00, q_angle_i}; mb = 33'(ts); end
      kabf_pkg::OP_M_T11:   begin ma = 33'(ts); mb = 33'(c11_q); end
      kabf_pkg::OP_M_QG:    begin ma = {2'b00, q_gyro_i}; mb = 33'(ts); end
      kabf_pkg::OP_M_K0Y:   begin ma = 33'(k0_q); mb = 33'(y_q); end
      kabf_pkg::OP_M_K1Y:   begin ma = 33'(k1_q); mb = 33'(y_q); end
      kabf_pkg::OP_M_K0P00: begin ma = 33'(k0_q); mb = 33'(p00_q); end
      kabf_pkg::OP_M_K0P01: begin ma = 33'(k0_q); mb = 33'(p01_q); end
      kabf_pkg::OP_M_K1P00: begin ma = 33'(k1_q); mb = 33'(p00_q); end
      kabf_pkg::OP_M_K1P01: begin ma = 33'(k1_q); mb = 33'(p01_q); end
      default:              begin ma = '0; mb = '0; end
    endcase
  end

  // rounded product: floor((a*b + half) >> frac)
  assign prod = 66'(ma) * 66'(mb);
  assign rnd  = prod + (66'sd1 <<< (CovFrac - 1));
  assign mres = rnd >>> CovFrac;

  // divider for the two gains
  logic               div_start;
  logic signed [31:0] div_p;
  logic signed [31:0] div_q;
  logic               div_busy;
  logic               s_pos;

  assign s_pos     = (s_q > 34'sd0);
  assign div_start = s_pos && (cmd_i.op == kabf_pkg::OP_DIV0_START
                               || cmd_i.op == kabf_pkg::OP_DIV1_START);
  assign div_p     = (cmd_i.op == kabf_pkg::OP_DIV1_START) ? p10_q : p00_q;

  kabf_div #(.CovFrac(CovFrac)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (div_p),
    .s_i     (s_q[32:0]),
    .busy_o  (div_busy),
    .q_o     (div_q)
  );

  assign sts_o.div_busy = div_busy;

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      bias_q  <= '0;
      c00_q   <= '0;
      c01_q   <= '0;
      c10_q   <= '0;
      c11_q   <= '0;
    end else if (cmd_i.op == kabf_pkg::OP_COMMIT) begin
      angle_q <= kabf_pkg::sat32(66'(pred_q) + 66'(mk0y_q));
      bias_q  <= kabf_pkg::sat32(66'(bias_q) + 66'(mk1y_q));
      c00_q   <= kabf_pkg::sat32(66'(p00_q) - 66'(mk0p00_q));
      c01_q   <= kabf_pkg::sat32(66'(p01_q) - 66'(mk0p01_q));
      c10_q   <= kabf_pkg::sat32(66'(p10_q) - 66'(mk1p00_q));
      c11_q   <= kabf_pkg::sat32(66'(p11_q) - 66'(mk1p01_q));
    end
  end

  // working registers, updated as each micro-op commands
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      kabf_pkg::OP_LOAD: begin
        acc_q  <= acc_angle_i;
        rate_q <= gyro_rate_i;
      end
      kabf_pkg::OP_M_PRED:  mpred_q <= mres[63:0];
      kabf_pkg::OP_M_T10:   mt10_q  <= mres[63:0];
      kabf_pkg::OP_M_T01:   mt01_q  <= mres[63:0];
      kabf_pkg::OP_M_QA:    mqa_q   <= mres[63:0];
      kabf_pkg::OP_M_T11:   mt11_q  <= mres[63:0];
      kabf_pkg::OP_M_QG:    mqg_q   <= mres[63:0];
      kabf_pkg::OP_FORM_P: begin
        pred_q <= kabf_pkg::sat32(66'(angle_q) + 66'(mpred_q));
        p00_q  <= kabf_pkg::sat32(66'(c00_q) - 66'(mt10_q) - 66'(mt01_q) + 66'(mqa_q));
        p01_q  <= kabf_pkg::sat32(66'(c01_q) - 66'(mt11_q));
        p10_q  <= kabf_pkg::sat32(66'(c10_q) - 66'(mt11_q));
        p11_q  <= kabf_pkg::sat32(66'(c11_q) + 66'(mqg_q));
      end
      kabf_pkg::OP_FORM_S: begin
        s_q <= 34'(p00_q) + 34'(r_angle_i);
        y_q <= kabf_pkg::sat32(66'(acc_q) - 66'(pred_q));
      end
      kabf_pkg::OP_DIV0_START: k0_q <= '0;
      kabf_pkg::OP_DIV1_START: begin
        k1_q <= '0;
        if (s_pos) k0_q <= div_q;
      end
      kabf_pkg::OP_M_K0Y: begin
        if (s_pos) k1_q <= div_q;
      end
      default: ;
    endcase
    // gain products, captured in their own step
    unique case (cmd_i.op)
      kabf_pkg::OP_M_K0Y:   mk0y_q   <= mres[63:0];
      kabf_pkg::OP_M_K1Y:   mk1y_q   <= mres[63:0];
      kabf_pkg::OP_M_K0P00: mk0p00_q <= mres[63:0];
      kabf_pkg::OP_M_K0P01: mk0p01_q <= mres[63:0];
      kabf_pkg::OP_M_K1P00: mk1p00_q <= mres[63:0];
      kabf_pkg::OP_M_K1P01: mk1p01_q <= mres[63:0];
      default: ;
    endcase
  end

  assign angle_o = angle_q;
endmodule

// ===== sv/kabf_ctrl.sv =====
// ----------------------------------------------------------------------------
// kabf_ctrl: sequencer for the filter datapath
// Steps through predict, divide and correct, then presents the result.
// ----------------------------------------------------------------------------
module kabf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kabf_pkg::dp_cmd_t  cmd_o,
  input  kabf_pkg::dp_sts_t  sts_i
);
  kabf_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kabf_pkg::ST_IDLE:      if (in_valid_i) state_d = kabf_pkg::ST_LOAD;
      kabf_pkg::ST_LOAD:      state_d = kabf_pkg::ST_M_PRED;
      kabf_pkg::ST_M_PRED:    state_d = kabf_pkg::ST_M_T10;
      kabf_pkg::ST_M_T10:     state_d = kabf_pkg::ST_M_T01;
      kabf_pkg::ST_M_T01:     state_d = kabf_pkg::ST_M_QA;
      kabf_pkg::ST_M_QA:      state_d = kabf_pkg::ST_M_T11;
      kabf_pkg::ST_M_T11:     state_d = kabf_pkg::ST_M_QG;
      kabf_pkg::ST_M_QG:      state_d = kabf_pkg::ST_FORM_P;
      kabf_pkg::ST_FORM_P:    state_d = kabf_pkg::ST_FORM_S;
      kabf_pkg::ST_FORM_S:    state_d = kabf_pkg::ST_DIV0;
      kabf_pkg::ST_DIV0:      state_d = kabf_pkg::ST_DIV0_WAIT;
      kabf_pkg::ST_DIV0_WAIT: if (!sts_i.div_busy) state_d = kabf_pkg::ST_DIV1;
      kabf_pkg::ST_DIV1:      state_d = kabf_pkg::ST_DIV1_WAIT;
      kabf_pkg::ST_DIV1_WAIT: if (!sts_i.div_busy) state_d = kabf_pkg::ST_M_K0Y;
      kabf_pkg::ST_M_K0Y:     state_d = kabf_pkg::ST_M_K1Y;
      kabf_pkg::ST_M_K1Y:     state_d = kabf_pkg::ST_M_K0P00;
      kabf_pkg::ST_M_K0P00:   state_d = kabf_pkg::ST_M_K0P01;
      kabf_pkg::ST_M_K0P01:   state_d = kabf_pkg::ST_M_K1P00;
      kabf_pkg::ST_M_K1P00:   state_d = kabf_pkg::ST_M_K1P01;
      kabf_pkg::ST_M_K1P01:   state_d = kabf_pkg::ST_COMMIT;
      kabf_pkg::ST_COMMIT:    state_d = kabf_pkg::ST_OUT;
      kabf_pkg::ST_OUT:       if (out_ready_i) state_d = kabf_pkg::ST_IDLE;
      default:                state_d = kabf_pkg::ST_IDLE;
    endcase
  end

  // at most one datapath op per state; the sample is loaded on the accept cycle
  always_comb begin
    cmd_o.op    = kabf_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      kabf_pkg::ST_IDLE:      in_ready_o = 1'b1;
      kabf_pkg::ST_LOAD:      cmd_o.op = kabf_pkg::OP_NONE;
      kabf_pkg::ST_M_PRED:    cmd_o.op = kabf_pkg::OP_M_PRED;
      kabf_pkg::ST_M_T10:     cmd_o.op = kabf_pkg::OP_M_T10;
      kabf_pkg::ST_M_T01:     cmd_o.op = kabf_pkg::OP_M_T01;
      kabf_pkg::ST_M_QA:      cmd_o.op = kabf_pkg::OP_M_QA;
      kabf_pkg::ST_M_T11:     cmd_o.op = kabf_pkg::OP_M_T11;
      kabf_pkg::ST_M_QG:      cmd_o.op = kabf_pkg::OP_M_QG;
      kabf_pkg::ST_FORM_P:    cmd_o.op = kabf_pkg::OP_FORM_P;
      kabf_pkg::ST_FORM_S:    cmd_o.op = kabf_pkg::OP_FORM_S;
      kabf_pkg::ST_DIV0:      cmd_o.op = kabf_pkg::OP_DIV0_START;
      kabf_pkg::ST_DIV1:      cmd_o.op = kabf_pkg::OP_DIV1_START;
      kabf_pkg::ST_M_K0Y:     cmd_o.op = kabf_pkg::OP_M_K0Y;
      kabf_pkg::ST_M_K1Y:     cmd_o.op = kabf_pkg::OP_M_K1Y;
      kabf_pkg::ST_M_K0P00:   cmd_o.op = kabf_pkg::OP_M_K0P00;
      kabf_pkg::ST_M_K0P01:   cmd_o.op = kabf_pkg::OP_M_K0P01;
      kabf_pkg::ST_M_K1P00:   cmd_o.op = kabf_pkg::OP_M_K1P00;
      kabf_pkg::ST_M_K1P01:   cmd_o.op = kabf_pkg::OP_M_K1P01;
      kabf_pkg::ST_COMMIT:    cmd_o.op = kabf_pkg::OP_COMMIT;
      kabf_pkg::ST_OUT:       out_valid_o = 1'b1;
      default:                cmd_o.op = kabf_pkg::OP_NONE;
    endcase
    if (state_q == kabf_pkg::ST_IDLE && in_valid_i) begin
      cmd_o.op = kabf_pkg::OP_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kabf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
